[rtl/led_chase_brightness_defines.svh]
// Assertion macros for the checker file of the chase brightness block.
`ifndef LED_CHASE_BRIGHTNESS_DEFINES_SVH
`define LED_CHASE_BRIGHTNESS_DEFINES_SVH

// Overlapping implication on the rising clock, switched off while in reset.
`define LCB_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Non-overlapping implication on the rising clock, switched off while in reset.
`define LCB_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

[rtl/lcb_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and the width gain table of the chase brightness block.
package lcb_pkg;

    localparam int FRAC_BITS = 16;
    localparam int PHASE_W   = 16;
    localparam int DIN_W     = 17;
    localparam int OUT_W     = 24;
    localparam int CFG_W     = 8;
    localparam int WIDTH_W   = 8;
    localparam int MODE_W    = 3;
    localparam int IDX_W     = 1;
    localparam int TAB_DEPTH = 1 << WIDTH_W;

    // Distance in Q.16 stays below three
    localparam int DIST_W    = 18;
    // Gain stays below sixteen
    localparam int GAIN_W    = FRAC_BITS + 4;
    localparam int PROD_W    = DIST_W + GAIN_W;
    localparam int SCALED_W  = PROD_W - 15;
    localparam int RES_A_W   = (SCALED_W > FRAC_BITS + 1) ? SCALED_W : FRAC_BITS + 1;
    localparam int RES_W     = ((RES_A_W > OUT_W) ? RES_A_W : OUT_W) + 1;

    localparam logic [DIST_W-1:0] ONE_Q16  = DIST_W'(65536);
    localparam logic [DIST_W-1:0] HALF_Q16 = DIST_W'(32768);
    localparam logic [DIST_W-1:0] TWO_Q16  = DIST_W'(131072);

    localparam logic [63:0] LN2_Q30    = (64'd693147180 << 30) / 64'd1000000000;
    localparam logic [63:0] GAIN_A_Q30 = (64'd5917642550 << 30) / 64'd1000000000;
    localparam logic [63:0] GAIN_C_Q30 = (64'd14034983296 << 30) / 64'd1000000000;

    typedef enum logic [MODE_W-1:0] {
        MODE_OFF     = 3'd0,
        MODE_BOUNCE  = 3'd1,
        MODE_OUTWARD = 3'd2,
        MODE_INWARD  = 3'd3,
        MODE_CENTER  = 3'd4,
        MODE_CW      = 3'd5,
        MODE_CCW     = 3'd6
    } mode_t;

    typedef enum logic [IDX_W-1:0] {
        REG_MODE  = 1'b0,
        REG_WIDTH = 1'b1
    } reg_idx_t;

    typedef struct packed {
        mode_t               mode;
        logic [GAIN_W-1:0]   gain;
    } cfg_t;

    typedef struct packed {
        logic                zero;
        logic [DIST_W-1:0]   span;
    } dist_stage_t;

    typedef logic [GAIN_W-1:0] gain_tab_t [TAB_DEPTH];

    function automatic logic [63:0] log2_q30(input logic [63:0] n);
        logic [63:0] k;
        logic [63:0] x;
        logic [63:0] frac;
        k    = '0;
        frac = '0;
        for (int j = 1; j <= WIDTH_W; j++)
        begin
            if ((n >> j) != 64'd0)
            begin
                k = 64'(j);
            end
        end
        x = (n << 30) >> k;
        for (int i = 0; i < 30; i++)
        begin
            x = (x * x) >> 30;
            if (x >= (64'd2 << 30))
            begin
                x    = x >> 1;
                frac = frac | (64'd1 << (29 - i));
            end
        end
        return (k << 30) | frac;
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] val);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bit_v;
        v     = val;
        res   = '0;
        bit_v = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (v >= res + bit_v)
            begin
                v   = v - (res + bit_v);
                res = (res >> 1) + bit_v;
            end
            else
            begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    function automatic logic [GAIN_W-1:0] width_gain(input int w);
        logic [63:0] n;
        logic [63:0] ln_q60;
        logic [63:0] s;
        logic [63:0] prod;
        logic [63:0] g;
        n      = 64'(TAB_DEPTH - w);
        ln_q60 = log2_q30(n) * LN2_Q30;
        s      = isqrt64(ln_q60);
        prod   = (GAIN_A_Q30 * s + (64'd1 << 29)) >> 30;
        g      = (GAIN_C_Q30 > prod) ? GAIN_C_Q30 - prod : 64'd0;
        g      = (g + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
        return GAIN_W'(g);
    endfunction

    function automatic gain_tab_t build_gain_tab();
        gain_tab_t tab;
        for (int w = 0; w < TAB_DEPTH; w++)
        begin
            tab[w] = width_gain(w);
        end
        return tab;
    endfunction

    localparam gain_tab_t GAIN_TAB = build_gain_tab();

endpackage

[rtl/lcb_cfg.sv]
`timescale 1ns / 1ps
// Configuration registers: chase mode and the width gain looked up on write.
module lcb_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [lcb_pkg::IDX_W-1:0]   cfg_index,
    input  logic [lcb_pkg::CFG_W-1:0]   cfg_data,
    output lcb_pkg::cfg_t               cfg
);
    import lcb_pkg::*;

    mode_t             mode_reg, mode_next;
    logic [GAIN_W-1:0] gain_reg, gain_next;

    // Hold the gain rather than the width: the table is read once per write
    always_comb
    begin
        mode_next = mode_reg;
        gain_next = gain_reg;
        if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_MODE:  mode_next = mode_t'(cfg_data[MODE_W-1:0]);
                REG_WIDTH: gain_next = GAIN_TAB[cfg_data[WIDTH_W-1:0]];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_OFF;
            gain_reg <= GAIN_TAB[0];
        end
        else
        begin
            mode_reg <= mode_next;
            gain_reg <= gain_next;
        end
    end

    assign cfg.mode = mode_reg;
    assign cfg.gain = gain_reg;

endmodule

[rtl/lcb_dist.sv]
`timescale 1ns / 1ps
// First pipeline stage: clamp and fold the pixel distance, pick the circular distance.
module lcb_dist (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        up_ready,
    input  logic [lcb_pkg::PHASE_W-1:0] cycle_phase,
    input  logic [lcb_pkg::DIN_W-1:0]   pixel_distance,
    input  lcb_pkg::mode_t              mode,
    output logic                        s1_valid,
    input  logic                        down_ready,
    output lcb_pkg::dist_stage_t        s1_data
);
    import lcb_pkg::*;

    logic [DIST_W-1:0] c;
    logic [DIST_W-1:0] d;
    logic [DIST_W-1:0] e;
    logic [DIST_W-1:0] a;
    dist_stage_t       s1_next;
    dist_stage_t       s1_reg;
    logic              valid_reg, valid_next;

    always_comb
    begin
        c = DIST_W'(cycle_phase);
        d = (DIST_W'(pixel_distance) > ONE_Q16) ? ONE_Q16 : DIST_W'(pixel_distance);
        e = (d <= HALF_Q16) ? d : ONE_Q16 - d;
        a = '0;
        s1_next.zero = 1'b0;
        s1_next.span = '0;
        unique case (mode)
            MODE_BOUNCE:
            begin
                if (c < HALF_Q16)
                begin
                    a = c << 1;
                    s1_next.span = (d <= a) ? a - d : a + d;
                end
                else
                begin
                    a = TWO_Q16 - (c << 1);
                    s1_next.span = (d >= a) ? d - a : TWO_Q16 - d - a;
                end
            end
            MODE_OUTWARD:
                s1_next.span = (ONE_Q16 - c <= e) ? TWO_Q16 + c - e : c + e;
            MODE_INWARD:
                s1_next.span = (c >= e) ? c + e : e + ONE_Q16 - c;
            MODE_CENTER:
            begin
                if (c <= HALF_Q16)
                begin
                    a = HALF_Q16 - c;
                    s1_next.span = (e < a) ? ONE_Q16 - e - a : e - a;
                end
                else
                begin
                    a = TWO_Q16 - c;
                    s1_next.span = (e < a) ? a - e : e + a;
                end
            end
            MODE_CW:
                s1_next.span = (ONE_Q16 - c <= d) ? d + c - ONE_Q16 : c + d;
            MODE_CCW:
                s1_next.span = (c >= d) ? c - d : c + ONE_Q16 - d;
            default:
                s1_next.zero = 1'b1;
        endcase
    end

    assign up_ready   = !valid_reg || down_ready;
    assign valid_next = up_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && up_ready)
        begin
            s1_reg <= s1_next;
        end
    end

    assign s1_valid = valid_reg;
    assign s1_data  = s1_reg;

endmodule

[rtl/lcb_scale.sv]
`timescale 1ns / 1ps
// Second and third pipeline stages: scale by the width gain, then round and saturate.
module lcb_scale (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s1_valid,
    output logic                              s1_ready,
    input  lcb_pkg::dist_stage_t              s1_data,
    input  logic [lcb_pkg::GAIN_W-1:0]        gain,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [lcb_pkg::OUT_W-1:0]  effect_level
);
    import lcb_pkg::*;

    localparam logic [PROD_W:0] ROUND_HALF = (PROD_W + 1)'(1) << 15;
    localparam logic [RES_W-1:0] UNIT_RES  = RES_W'(1) << FRAC_BITS;
    localparam logic [RES_W-1:0] SAT_MAX   = {{(RES_W - OUT_W + 1){1'b0}}, {(OUT_W - 1){1'b1}}};
    localparam logic [RES_W-1:0] SAT_MIN   = {{(RES_W - OUT_W + 1){1'b1}}, {(OUT_W - 1){1'b0}}};

    logic                s2_valid_reg, s2_valid_next;
    logic                s2_zero_reg;
    logic [PROD_W-1:0]   s2_prod_reg;
    logic                s2_ready;
    logic                out_valid_reg, out_valid_next;
    logic                out_ready;
    logic [OUT_W-1:0]    level_reg, level_next;
    logic [PROD_W:0]     rounded;
    logic [SCALED_W-1:0] scaled;
    logic [RES_W-1:0]    res;

    assign out_ready = !out_valid_reg || !out_stall;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = s2_ready;

    assign s2_valid_next  = s2_ready ? s1_valid : s2_valid_reg;
    assign out_valid_next = out_ready ? s2_valid_reg : out_valid_reg;

    // Round the Q.32 product to Q.16, subtract from one, clip to the output range; zero for the off mode
    always_comb
    begin
        rounded = {1'b0, s2_prod_reg} + ROUND_HALF;
        scaled  = rounded[PROD_W:16];
        res     = UNIT_RES - RES_W'(scaled);
        if (s2_zero_reg)
        begin
            level_next = '0;
        end
        else if ($signed(res) > $signed(SAT_MAX))
        begin
            level_next = SAT_MAX[OUT_W-1:0];
        end
        else if ($signed(res) < $signed(SAT_MIN))
        begin
            level_next = SAT_MIN[OUT_W-1:0];
        end
        else
        begin
            level_next = res[OUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid && s2_ready)
        begin
            s2_zero_reg <= s1_data.zero;
            s2_prod_reg <= PROD_W'(s1_data.span) * PROD_W'(gain);
        end
        if (s2_valid_reg && out_ready)
        begin
            level_reg <= level_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign effect_level = $signed(level_reg);

endmodule

[rtl/led_chase_brightness.sv]
`timescale 1ns / 1ps
// Chase brightness block: per-pixel effect level for an LED chase pattern.
//
// Input channel (in_valid / in_stall): one transfer per pixel carries the chase
// cycle phase, unsigned Q0.16, and the pixel's distance along the strip, unsigned Q1.16.
// Output channel (out_valid / out_stall): one transfer per pixel carries the
// signed Q7.16 effect level, saturated, in the order the pixels came in.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 chase mode,
// 1 chase width). Write only while no pixel is in flight. The width gain is
// looked up from a 256-entry constant table at the write, not per pixel.
//
// Pipeline: three register stages (distance, multiply, round and saturate); a
// pixel passes them in that order before it shows on out_valid. Throughput:
// one pixel every cycle while the output side does not stall, set by the
// pipeline carrying one multiplier in its middle stage.
// Reset clears every valid bit, sets mode to off and the gain to that of width zero.
// When the receiver stalls, hold the result on the port; the stages behind it
// fill up one by one, and in_stall rises only once all three stages are full.
module led_chase_brightness (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [lcb_pkg::IDX_W-1:0]         cfg_index,
    input  logic [lcb_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [lcb_pkg::PHASE_W-1:0]       cycle_phase,
    input  logic [lcb_pkg::DIN_W-1:0]         pixel_distance,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [lcb_pkg::OUT_W-1:0]  effect_level
);
    import lcb_pkg::*;

    cfg_t        cfg;
    logic        up_ready;
    logic        s1_valid;
    logic        s1_ready;
    dist_stage_t s1_data;

    // The user must keep mode and gain static while pixels flow; the block does not enforce it
    lcb_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Stage one: circular distance to the active point
    lcb_dist u_dist (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .up_ready       (up_ready),
        .cycle_phase    (cycle_phase),
        .pixel_distance (pixel_distance),
        .mode           (cfg.mode),
        .s1_valid       (s1_valid),
        .down_ready     (s1_ready),
        .s1_data        (s1_data)
    );

    // Stages two and three: scale, round, saturate, drive the output register
    lcb_scale u_scale (
        .clk          (clk),
        .rst_n        (rst_n),
        .s1_valid     (s1_valid),
        .s1_ready     (s1_ready),
        .s1_data      (s1_data),
        .gain         (cfg.gain),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .effect_level (effect_level)
    );

    // Stall the sender only when the stage-one register is full and blocked
    assign in_stall = !up_ready;

endmodule

[rtl/lcb_check.sv]
`timescale 1ns / 1ps
// Port-level checker for the chase brightness block, bound to the top level.
`include "led_chase_brightness_defines.svh"

module lcb_check (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic [lcb_pkg::PHASE_W-1:0]       cycle_phase,
    input logic [lcb_pkg::DIN_W-1:0]         pixel_distance,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic signed [lcb_pkg::OUT_W-1:0]  effect_level
);

    // Hold a stalled pixel on the input port
    `LCB_ASSERT_NXT(a_in_hold, in_valid && in_stall, in_valid && $stable(cycle_phase) && $stable(pixel_distance))

    // Hold a stalled result on the port
    `LCB_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(effect_level))

    // Back-pressure reaches the input only through a full, stalled output
    `LCB_ASSERT_IMP(a_stall_cause, in_stall, out_valid && out_stall)

    // A transfer whose output side then does not stall has reached the output register
    `LCB_ASSERT_NXT(a_latency, (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall, out_valid)

endmodule

bind led_chase_brightness lcb_check u_lcb_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .cycle_phase    (cycle_phase),
    .pixel_distance (pixel_distance),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .effect_level   (effect_level)
);
